>>> hw/rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants for the CAN signal extract/scale block.
// ----------------------------------------------------------------------------
package cse_pkg;

	localparam int FIELD_MAX_BITS = 32;
	localparam int FRAC_BITS      = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam int DIV_BITS       = 4;   // quotient bits per divider stage
	localparam int DIV_STAGES     = 64 / DIV_BITS;

	localparam logic [2:0] REG_MATCH_ID   = 3'd0;
	localparam logic [2:0] REG_MATCH_MASK = 3'd1;
	localparam logic [2:0] REG_SUB_INDEX  = 3'd2;
	localparam logic [2:0] REG_FIELD_SPAN = 3'd3;
	localparam logic [2:0] REG_FORMAT     = 3'd4;
	localparam logic [2:0] REG_SCALE_MUL  = 3'd5;
	localparam logic [2:0] REG_SCALE_DIV  = 3'd6;
	localparam logic [2:0] REG_SCALE_OFS  = 3'd7;

	localparam logic [1:0] TYPE_UNSIGNED = 2'd0;
	localparam logic [1:0] TYPE_SIGNED   = 2'd1;
	localparam logic [1:0] TYPE_FLOAT    = 2'd2;
	localparam logic [1:0] TYPE_SIGNMAG  = 2'd3;

	typedef enum logic [1:0] {
		KIND_DROP,  // no match, NaN or infinity times zero: empty result
		KIND_INF,   // float infinity: saturate with sign
		KIND_NUM    // ordinary value
	} kind_t;

	typedef struct packed {
		logic [28:0]        match_id;
		logic [28:0]        match_mask;
		logic signed [8:0]  sub_index;
		logic [11:0]        field_span;
		logic [3:0]         format_mode;
		logic signed [31:0] scale_multiplier;
		logic [15:0]        scale_divider;
		logic signed [31:0] scale_offset;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic               neg;   // sign of an infinity
		logic signed [32:0] m;
		logic signed [8:0]  e;
	} dec_t;

endpackage

>>> hw/rtl/cse_if.sv
// ----------------------------------------------------------------------------
// cse_if
// Frame and result channels, valid/ready.
// ----------------------------------------------------------------------------
interface cse_frame_if;
	logic        valid;
	logic        ready;
	logic [28:0] frame_id;
	logic [63:0] payload;
	modport source (output valid, frame_id, payload, input ready);
	modport sink   (input valid, frame_id, payload, output ready);
endinterface

interface cse_result_if;
	logic        valid;
	logic        ready;
	logic        matched;
	logic [63:0] scaled_value;
	logic        saturated;
	modport source (output valid, matched, scaled_value, saturated, input ready);
	modport sink   (input valid, matched, scaled_value, saturated, output ready);
endinterface

>>> hw/rtl/cse_front.sv
// ----------------------------------------------------------------------------
// cse_front
// Match, field extraction, byte order and type decode of one frame.
// ----------------------------------------------------------------------------
module cse_front import cse_pkg::*; (
	input  cfg_t        cfg,
	input  logic [28:0] frame_id,
	input  logic [63:0] payload,
	output dec_t        dec
);

	logic        hit;
	logic [28:0] id_m;
	logic [8:0]  off;
	logic [8:0]  len_raw;
	logic [5:0]  len;
	logic [63:0] sh;
	logic [31:0] raw;
	logic [31:0] fld;
	logic [2:0]  nb;
	logic [1:0]  ftype;
	logic [7:0]  ex;
	logic [22:0] fr;
	logic [31:0] sgn;
	logic [32:0] mag;

	always_comb begin
		id_m = (cfg.match_mask != '0) ? (frame_id & cfg.match_mask) : frame_id;
		hit  = (cfg.match_id == '0) ||
			((id_m == cfg.match_id) &&
			 (cfg.sub_index[8] || (cfg.sub_index[7:0] == payload[63:56])));

		off     = {3'd0, cfg.field_span[5:0]};
		len_raw = {3'd0, cfg.field_span[11:6]};
		if (!cfg.format_mode[0]) begin
			off     = off << 3;
			len_raw = len_raw << 3;
		end
		len = (len_raw > 9'(FIELD_MAX_BITS)) ? 6'(FIELD_MAX_BITS) : len_raw[5:0];

		sh  = payload << off[5:0];
		raw = '0;
		if (off < 9'd64 && len != '0)
			raw = sh[63:32] >> (6'd32 - len);

		// little endian: reverse the low ceil(len/8) bytes
		nb  = 3'((len + 6'd7) >> 3);
		fld = raw;
		if (!cfg.format_mode[1]) begin
			case (nb)
				3'd2:    fld = {16'd0, raw[7:0], raw[15:8]};
				3'd3:    fld = {8'd0, raw[7:0], raw[15:8], raw[23:16]};
				3'd4:    fld = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
				default: fld = raw;
			endcase
		end

		ftype = cfg.format_mode[3:2];
		ex    = fld[30:23];
		fr    = fld[22:0];
		sgn   = (len == '0) ? 32'd0 : (32'd1 << (len - 6'd1));

		dec.kind = hit ? KIND_NUM : KIND_DROP;
		dec.neg  = 1'b0;
		dec.m    = '0;
		dec.e    = '0;
		mag      = '0;
		unique case (ftype)
			TYPE_UNSIGNED: dec.m = {1'b0, fld};
			TYPE_SIGNED: begin
				if (len <= 6'd8)
					dec.m = 33'(signed'(fld[7:0]));
				else if (len <= 6'd16)
					dec.m = 33'(signed'(fld[15:0]));
				else
					dec.m = 33'(signed'(fld));
			end
			TYPE_FLOAT: begin
				if (ex == 8'hFF) begin
					dec.neg = fld[31] ^ cfg.scale_multiplier[31];
					if (fr != '0 || cfg.scale_multiplier == '0)
						dec.kind = KIND_DROP;
					else if (hit)
						dec.kind = KIND_INF;
				end else if (ex == 8'd0) begin
					mag   = {10'd0, fr};
					dec.e = -9'sd149;
				end else begin
					mag   = {9'd0, 1'b1, fr};
					dec.e = 9'(signed'({1'b0, ex}) - 10'sd150);
				end
				dec.m = fld[31] ? -mag : mag;
			end
			TYPE_SIGNMAG: begin
				if (len != '0) begin
					if (fld < sgn)
						dec.m = {1'b0, fld};
					else
						dec.m = -{1'b0, fld & (sgn - 32'd1)};
				end
			end
			default: dec.m = '0;
		endcase
	end

endmodule

>>> hw/rtl/cse_queue.sv
// ----------------------------------------------------------------------------
// cse_queue
// Short queue of decoded words between front and back.
// ----------------------------------------------------------------------------
module cse_queue import cse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dec_t push_data,
	input  logic pop,
	output logic full,
	output logic empty,
	output dec_t head
);

	localparam int AW = $clog2(QUEUE_DEPTH);

	dec_t          mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign full  = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> hw/rtl/cse_back.sv
// ----------------------------------------------------------------------------
// cse_back
// Multiply, pipelined divide, power-of-two scale, offset and saturation.
// ----------------------------------------------------------------------------
module cse_back import cse_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         in_valid,
	input  dec_t         in_dec,
	output logic         advance,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         out_matched,
	output logic [63:0]  out_value,
	output logic         out_sat
);

	typedef struct packed {
		kind_t       kind;
		logic        neg;
		logic signed [8:0] e;
		logic [15:0] rem;
		logic [63:0] dq;
	} div_t;

	localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] S64_MIN = {1'b1, 63'd0};

	function automatic div_t div_step(input div_t d, input logic [15:0] dv);
		div_t r;
		logic [16:0] t;
		r = d;
		for (int i = 0; i < DIV_BITS; i++) begin
			t    = {r.rem, r.dq[63]};
			r.dq = r.dq << 1;
			if (t >= {1'b0, dv}) begin
				r.rem   = 16'(t - {1'b0, dv});
				r.dq[0] = 1'b1;
			end else begin
				r.rem = t[15:0];
			end
		end
		return r;
	endfunction

	// v * 2^k on sign/magnitude: floor on right shifts, saturate on left
	function automatic logic [64:0] pow2_scale(input logic neg, input logic [63:0] mag,
			input logic signed [9:0] k);
		logic [63:0] lim;
		logic [63:0] m2;
		logic [9:0]  s;
		logic        sat;
		sat = 1'b0;
		m2  = '0;
		lim = neg ? S64_MIN : S64_MAX;
		s   = -k;
		if (mag == '0) begin
			m2 = '0;
		end else if (!k[9]) begin
			if (k > 10'sd63 || mag > (lim >> k[5:0])) begin
				sat = 1'b1;
				m2  = lim;
			end else begin
				m2 = mag << k[5:0];
			end
		end else if (s >= 10'd64) begin
			m2 = neg ? 64'd1 : 64'd0;
		end else if (neg) begin
			m2 = ((mag - 64'd1) >> s[5:0]) + 64'd1;
		end else begin
			m2 = mag >> s[5:0];
		end
		return {sat, neg ? -m2 : m2};
	endfunction

	logic        v_s1;
	dec_t        dec_s1;
	logic signed [63:0] p_s1;

	logic        v_s2;
	div_t        div_s2;

	logic        v_div [DIV_STAGES];
	div_t        div_sd [DIV_STAGES];

	logic        v_s3;
	kind_t       kind_s3;
	logic        neg_s3;
	logic [63:0] r_s3;
	logic        sat_s3;

	logic        out_valid_q;
	logic        out_matched_q;
	logic [63:0] out_value_q;
	logic        out_sat_q;

	logic [15:0] divisor;
	logic [64:0] prod;
	logic        pneg;
	div_t        div_last;
	logic        qneg;
	logic [64:0] sc;
	logic        oneg;
	logic [63:0] omag;
	logic [64:0] ofs;
	logic [64:0] sum;
	logic signed [9:0] k;

	assign advance   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_matched = out_matched_q;
	assign out_value   = out_value_q;
	assign out_sat     = out_sat_q;

	assign divisor = (cfg.scale_divider == '0) ? 16'd1 : cfg.scale_divider;
	assign prod    = 65'(in_dec.m * 65'(cfg.scale_multiplier));
	assign pneg    = p_s1[63];

	// s1: product
	always_ff @(posedge clk) begin
		if (advance) begin
			dec_s1 <= in_dec;
			p_s1   <= prod[63:0];
		end
	end

	// s2: sign and magnitude into the divider
	always_ff @(posedge clk) begin
		if (advance) begin
			div_s2.kind <= dec_s1.kind;
			div_s2.neg  <= (dec_s1.kind == KIND_INF) ? dec_s1.neg : pneg;
			div_s2.e    <= dec_s1.e;
			div_s2.rem  <= '0;
			div_s2.dq   <= pneg ? 64'(-p_s1) : 64'(p_s1);
		end
	end

	// divider stages
	always_ff @(posedge clk) begin
		if (advance) begin
			div_sd[0] <= div_step(div_s2, divisor);
			for (int i = 1; i < DIV_STAGES; i++)
				div_sd[i] <= div_step(div_sd[i-1], divisor);
		end
	end

	// s3: power-of-two scale to the output fraction
	assign div_last = div_sd[DIV_STAGES-1];
	assign qneg     = div_last.neg;
	assign k        = 10'(div_last.e) + 10'(FRAC_BITS - 16);
	assign sc       = pow2_scale(qneg, div_last.dq, k);

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s3 <= div_last.kind;
			neg_s3  <= qneg;
			r_s3    <= sc[63:0];
			sat_s3  <= sc[64];
		end
	end

	// output: offset add with saturation
	assign oneg = cfg.scale_offset[31];
	assign omag = 64'(oneg ? -33'(cfg.scale_offset) : 33'(cfg.scale_offset));
	assign ofs  = pow2_scale(oneg, omag, 10'(FRAC_BITS - 16));
	assign sum  = {r_s3[63], r_s3} + {ofs[63], ofs[63:0]};

	always_ff @(posedge clk) begin
		if (advance) begin
			out_matched_q <= 1'b0;
			out_value_q   <= '0;
			out_sat_q     <= 1'b0;
			case (kind_s3)
				KIND_INF: begin
					out_matched_q <= 1'b1;
					out_value_q   <= neg_s3 ? S64_MIN : S64_MAX;
					out_sat_q     <= 1'b1;
				end
				KIND_NUM: begin
					out_matched_q <= 1'b1;
					if (sum[64] != sum[63]) begin
						out_value_q <= sum[64] ? S64_MIN : S64_MAX;
						out_sat_q   <= 1'b1;
					end else begin
						out_value_q <= sum[63:0];
						out_sat_q   <= sat_s3 | ofs[64];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			for (int i = 0; i < DIV_STAGES; i++)
				v_div[i] <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_div[0]    <= v_s2;
			for (int i = 1; i < DIV_STAGES; i++)
				v_div[i] <= v_div[i-1];
			v_s3        <= v_div[DIV_STAGES-1];
			out_valid_q <= v_s3;
		end
	end

endmodule

>>> hw/rtl/can_signal_extract_scale.sv
// ----------------------------------------------------------------------------
// can_signal_extract_scale
// CAN frame match, signal extraction and fixed-point scaling (Q47.16 out).
// ----------------------------------------------------------------------------
//  channel   dir  handshake     word
//  frame     in   valid/ready   frame_id[28:0], payload[63:0]
//  result    out  valid/ready   matched, scaled_value[63:0], saturated
//  apb       in   psel/penable  8 regs at 4*i, 32-bit data
//
// One frame per cycle sustained while results are taken. The result word passes
// queue pop into product, abs, 16 divider stages of 4 quotient bits, scale and
// offset registers in turn.
// Reset (arst_n low) clears pipeline valids and queue pointers and loads register defaults.
// A stalled result freezes the back pipeline; the front keeps filling the
// 4-word queue and drops ready only when it is full.
// ----------------------------------------------------------------------------
module can_signal_extract_scale import cse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	cse_frame_if.sink          frame,
	cse_result_if.source       result
);

	cfg_t        cfg_q;
	dec_t        dec;
	dec_t        head;
	logic        q_full;
	logic        q_empty;
	logic        advance;
	logic        push;
	logic        pop;
	logic [2:0]  reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[4:2];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_id         <= '0;
			cfg_q.match_mask       <= '0;
			cfg_q.sub_index        <= -9'sd1;
			cfg_q.field_span       <= 12'd512;
			cfg_q.format_mode      <= '0;
			cfg_q.scale_multiplier <= 32'sd65536;
			cfg_q.scale_divider    <= '0;
			cfg_q.scale_offset     <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_MATCH_ID:   cfg_q.match_id         <= pwdata[28:0];
				REG_MATCH_MASK: cfg_q.match_mask       <= pwdata[28:0];
				REG_SUB_INDEX:  cfg_q.sub_index        <= pwdata[8:0];
				REG_FIELD_SPAN: cfg_q.field_span       <= pwdata[11:0];
				REG_FORMAT:     cfg_q.format_mode      <= pwdata[3:0];
				REG_SCALE_MUL:  cfg_q.scale_multiplier <= pwdata;
				REG_SCALE_DIV:  cfg_q.scale_divider    <= pwdata[15:0];
				REG_SCALE_OFS:  cfg_q.scale_offset     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MATCH_ID:   prdata = {3'd0, cfg_q.match_id};
			REG_MATCH_MASK: prdata = {3'd0, cfg_q.match_mask};
			REG_SUB_INDEX:  prdata = 32'(cfg_q.sub_index);
			REG_FIELD_SPAN: prdata = {20'd0, cfg_q.field_span};
			REG_FORMAT:     prdata = {28'd0, cfg_q.format_mode};
			REG_SCALE_MUL:  prdata = cfg_q.scale_multiplier;
			REG_SCALE_DIV:  prdata = {16'd0, cfg_q.scale_divider};
			REG_SCALE_OFS:  prdata = cfg_q.scale_offset;
			default:        prdata = '0;
		endcase
	end

	// front: classify straight into the queue
	cse_front u_front (
		.cfg      (cfg_q),
		.frame_id (frame.frame_id),
		.payload  (frame.payload),
		.dec      (dec)
	);

	assign frame.ready = !q_full;
	assign push        = frame.valid && !q_full;
	assign pop         = advance && !q_empty;

	cse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (dec),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	// back: arithmetic pipeline, stalls as a whole on result backpressure
	cse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (!q_empty),
		.in_dec      (head),
		.advance     (advance),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_matched (result.matched),
		.out_value   (result.scaled_value),
		.out_sat     (result.saturated)
	);

endmodule
